@@ rtl/slcs_pkg.sv @@
`default_nettype none

package slcs_pkg;

  localparam int unsigned CH_COUNT  = 8;
  localparam int unsigned LEVEL_W   = 12;
  localparam int unsigned MEAS_W    = 8;
  localparam int unsigned GAIN_W    = 10;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned PROD_W    = 20;
  localparam int unsigned SUM_W     = 22;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 12;
  localparam int unsigned DATA_W    = CH_COUNT * LEVEL_W;

  localparam logic [COUNT_W-1:0] SETTLE_LIMIT    = 8'd5;
  localparam logic [COUNT_W-1:0] ITERATION_LIMIT = 8'd60;
  localparam logic [LEVEL_W-1:0] LEVEL_FLOOR     = 12'd100;

  localparam logic [7:0]         AIM_RESET     = 8'd237;
  localparam logic [7:0]         TOL_RESET     = 8'd8;
  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 10'd512;
  localparam logic [LEVEL_W-1:0] CEILING_RESET = 12'd1333;

  // channel order within one sensor side
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_IR    = 3;
  localparam int unsigned SIDE_CH  = 4;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_START   = 1'b1;

  typedef enum logic [1:0] {
    MODE_COLOR = 2'd0,
    MODE_GRAY  = 2'd1,
    MODE_IR    = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AIM     = 3'd0,
    CFG_TOL     = 3'd1,
    CFG_GAIN    = 3'd2,
    CFG_CEILING = 3'd3,
    CFG_MODE    = 3'd4
  } cfg_idx_e;

  // floor(r * num / 5) for a 12-bit level, by reciprocal 2^17 / 5 rounded up
  localparam logic [14:0] RECIP_5     = 15'd26215;
  localparam int unsigned RECIP_SHIFT = 17;

  function automatic logic [LEVEL_W-1:0] scale_fifth(logic [LEVEL_W-1:0] r,
                                                     logic [2:0] num);
    logic [13:0] y;
    logic [28:0] p;
    y = 14'(r * num);
    p = 29'(y * RECIP_5);
    return p[RECIP_SHIFT +: LEVEL_W];
  endfunction

endpackage

`default_nettype wire

@@ rtl/slcs_adjust.sv @@
`default_nettype none

module slcs_adjust (
  input  wire logic [slcs_pkg::LEVEL_W-1:0]       level_i,
  input  wire logic signed [slcs_pkg::PROD_W-1:0] prod_i,
  input  wire logic [slcs_pkg::LEVEL_W-1:0]       ceiling_i,
  output logic      [slcs_pkg::LEVEL_W-1:0]       level_o
);
  import slcs_pkg::*;

  localparam logic signed [SUM_W-1:0] FLOOR_SUM = SUM_W'({LEVEL_FLOOR, 8'h00});

  logic signed [SUM_W-1:0] sum;
  logic [LEVEL_W:0]        floored;

  always_comb begin
    sum = $signed({2'b00, level_i, 8'h00})
        + $signed({{(SUM_W-PROD_W){prod_i[PROD_W-1]}}, prod_i});
    // raise to the floor first, then let the ceiling win
    if (sum < FLOOR_SUM) begin
      floored = {1'b0, LEVEL_FLOOR};
    end else begin
      floored = sum[8 +: LEVEL_W+1];
    end
    if (floored > {1'b0, ceiling_i}) begin
      level_o = ceiling_i;
    end else begin
      level_o = floored[LEVEL_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/scanner_light_calibration_step.sv @@
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: eight 12-bit fields, tuser: kind
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: eight levels, tlast: finished,
//                                             tuser: timed_out
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls; results go through the stage-one and
// result registers. Stage one registers the gain products, stage two adds them to the
// stored levels, clamps, applies the mode and updates the counters in the same cycle.
// Reset clears the eight levels and both counters and loads register defaults.
// An output stall holds the result; one more item is taken into stage one meanwhile.
`default_nettype none

module scanner_light_calibration_step (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // top R,G,B,IR then bottom R,G,B,IR, 12 bits each from bit 0 up
  input  wire logic [slcs_pkg::DATA_W-1:0]       s_axis_tdata,
  // bit 0: kind
  input  wire logic                              s_axis_tuser,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // drive top R,G,B,IR then bottom R,G,B,IR, 12 bits each from bit 0 up
  output logic [slcs_pkg::DATA_W-1:0]            m_axis_tdata,
  output logic                                   m_axis_tlast,
  // bit 0: timed_out
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [slcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [slcs_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import slcs_pkg::*;

  // configuration
  logic [7:0]         aim_q, tol_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [LEVEL_W-1:0] ceiling_q;
  logic [1:0]         mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aim_q     <= AIM_RESET;
      tol_q     <= TOL_RESET;
      gain_q    <= GAIN_RESET;
      ceiling_q <= CEILING_RESET;
      mode_q    <= MODE_COLOR;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_AIM:     aim_q     <= cfg_data_i[7:0];
        CFG_TOL:     tol_q     <= cfg_data_i[7:0];
        CFG_GAIN:    gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_CEILING: ceiling_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_MODE:    mode_q    <= cfg_data_i[1:0];
        default:     ;
      endcase
    end
  end

  // stage one: saturate, error, gain product
  logic                           p_valid_q;
  logic                           p_adv;
  logic                           s_xfer;
  logic                           out_free;

  logic signed [PROD_W-1:0]       prod_d   [CH_COUNT];
  logic signed [PROD_W-1:0]       prod_q   [CH_COUNT];
  logic [CH_COUNT-1:0]            off_d;
  logic                           bad_d, bad_q;
  logic                           kind_q;
  logic [DATA_W-1:0]              raw_q;

  always_comb begin
    logic [LEVEL_W-1:0]      meas;
    logic [MEAS_W-1:0]       m8;
    logic signed [MEAS_W:0]  diff;
    logic [MEAS_W:0]         mag;
    logic signed [GAIN_W:0]  gs;
    gs = $signed({1'b0, gain_q});
    for (int i = 0; i < CH_COUNT; i++) begin
      meas = s_axis_tdata[i*LEVEL_W +: LEVEL_W];
      m8   = (|meas[LEVEL_W-1:MEAS_W]) ? {MEAS_W{1'b1}} : meas[MEAS_W-1:0];
      diff = $signed({1'b0, aim_q}) - $signed({1'b0, m8});
      mag  = diff[MEAS_W] ? (MEAS_W+1)'(-diff) : diff;
      off_d[i]  = mag > {1'b0, tol_q};
      prod_d[i] = diff * gs;
    end
    unique case (mode_e'(mode_q))
      MODE_COLOR: bad_d = |{off_d[CH_RED], off_d[CH_GREEN], off_d[CH_BLUE],
                            off_d[SIDE_CH+CH_RED], off_d[SIDE_CH+CH_GREEN],
                            off_d[SIDE_CH+CH_BLUE]};
      MODE_GRAY:  bad_d = off_d[CH_RED] | off_d[SIDE_CH+CH_RED];
      MODE_IR:    bad_d = off_d[CH_IR] | off_d[SIDE_CH+CH_IR];
      default:    bad_d = 1'b0;
    endcase
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign p_adv         = p_valid_q && out_free;
  assign s_axis_tready = !p_valid_q || out_free;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (s_xfer) begin
      p_valid_q <= 1'b1;
    end else if (p_adv) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      prod_q <= prod_d;
      bad_q  <= bad_d;
      kind_q <= s_axis_tuser;
      raw_q  <= s_axis_tdata;
    end
  end

  // stage two: level update against stored state
  logic [LEVEL_W-1:0] lv_q   [CH_COUNT];
  logic [LEVEL_W-1:0] lv_d   [CH_COUNT];
  logic [LEVEL_W-1:0] adj    [CH_COUNT];
  logic [COUNT_W-1:0] settle_q, settle_d, iter_q, iter_d;
  logic               fin_d, tmo_d;

  for (genvar g = 0; g < CH_COUNT; g++) begin : g_adj
    slcs_adjust u_adjust (
      .level_i   (lv_q[g]),
      .prod_i    (prod_q[g]),
      .ceiling_i (ceiling_q),
      .level_o   (adj[g])
    );
  end

  always_comb begin
    logic [COUNT_W-1:0] settle_eff;
    logic               settled;
    logic               expired;
    lv_d       = adj;
    settle_eff = bad_q ? '0 : settle_q;
    settled    = settle_eff > SETTLE_LIMIT;
    expired    = iter_q > ITERATION_LIMIT;
    fin_d      = settled || expired;
    tmo_d      = !settled && expired;
    settle_d   = (&settle_eff) ? settle_eff : settle_eff + 1'b1;
    iter_d     = (settled || (&iter_q)) ? iter_q : iter_q + 1'b1;
    for (int s = 0; s < CH_COUNT; s += SIDE_CH) begin
      unique case (mode_e'(mode_q))
        MODE_COLOR: lv_d[s+CH_IR] = '0;
        MODE_GRAY: begin
          lv_d[s+CH_GREEN] = scale_fifth(adj[s+CH_RED], 3'd4);
          lv_d[s+CH_BLUE]  = scale_fifth(adj[s+CH_RED], 3'd3);
          lv_d[s+CH_IR]    = '0;
        end
        MODE_IR: begin
          lv_d[s+CH_RED]   = '0;
          lv_d[s+CH_GREEN] = '0;
          lv_d[s+CH_BLUE]  = '0;
        end
        default: ;
      endcase
    end
    if (kind_q == KIND_START) begin
      for (int i = 0; i < CH_COUNT; i++) begin
        lv_d[i] = raw_q[i*LEVEL_W +: LEVEL_W];
      end
      settle_d = '0;
      iter_d   = '0;
      fin_d    = 1'b0;
      tmo_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CH_COUNT; i++) begin
        lv_q[i] <= '0;
      end
      settle_q <= '0;
      iter_q   <= '0;
    end else if (p_adv) begin
      lv_q     <= lv_d;
      settle_q <= settle_d;
      iter_q   <= iter_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (p_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_adv) begin
      for (int i = 0; i < CH_COUNT; i++) begin
        m_axis_tdata[i*LEVEL_W +: LEVEL_W] <= lv_d[i];
      end
      m_axis_tlast <= fin_d;
      m_axis_tuser <= tmo_d;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_scanner_light_calibration_step.sv @@
`default_nettype none

module tb_scanner_light_calibration_step;
  timeunit 1ns;
  timeprecision 1ps;

  import slcs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 80;
  localparam int unsigned SATURATE_RUN   = 262;
  localparam logic [1:0]  MODE_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

  typedef logic [CH_COUNT-1:0][LEVEL_W-1:0] level_vec_t;

  typedef struct packed {
    level_vec_t lvl;
    logic       fin;
    logic       tmo;
  } drive_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic [DATA_W-1:0]    s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  // predictor copy of the block's registers and state
  logic [7:0]         aim_reg     = AIM_RESET;
  logic [7:0]         tol_reg     = TOL_RESET;
  logic [GAIN_W-1:0]  gain_reg    = GAIN_RESET;
  logic [LEVEL_W-1:0] ceiling_reg = CEILING_RESET;
  logic [1:0]         mode_reg    = MODE_COLOR;
  level_vec_t         drive_lvl   = '0;
  logic [COUNT_W-1:0] settle_cnt  = '0;
  logic [COUNT_W-1:0] iter_cnt    = '0;

  drive_result_t pending_drive[$];
  int unsigned   mismatch_count = 0;
  int unsigned   sent_items     = 0;
  int unsigned   idle_cycles    = 0;
  bit            no_idle        = 1'b0;

  scanner_light_calibration_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic off_target(logic [7:0] m);
    int e;
    e = (m > aim_reg) ? int'(m) - int'(aim_reg) : int'(aim_reg) - int'(m);
    return e > int'(tol_reg);
  endfunction

  // advance the predicted levels and counters by one item
  function automatic drive_result_t calibrate_step(logic kind, level_vec_t vals);
    drive_result_t res;
    logic [7:0]    meas [CH_COUNT];
    logic          bad;
    int            t;
    int            r;
    int            base;
    res = '0;
    bad = 1'b0;
    if (kind == KIND_START) begin
      drive_lvl  = vals;
      settle_cnt = '0;
      iter_cnt   = '0;
    end else begin
      for (int i = 0; i < CH_COUNT; i++) begin
        meas[i] = (vals[i] > 12'd255) ? 8'd255 : vals[i][7:0];
        t = int'(drive_lvl[i]) * 256 + (int'(aim_reg) - int'(meas[i])) * int'(gain_reg);
        if (t < int'(LEVEL_FLOOR) * 256) t = int'(LEVEL_FLOOR);
        else t = t >> 8;
        if (t > int'(ceiling_reg)) t = int'(ceiling_reg);
        drive_lvl[i] = LEVEL_W'(t);
      end
      for (int side = 0; side < 2; side++) begin
        base = side * SIDE_CH;
        case (mode_reg)
          MODE_COLOR: begin
            bad |= off_target(meas[base + CH_RED]) | off_target(meas[base + CH_GREEN])
                 | off_target(meas[base + CH_BLUE]);
            drive_lvl[base + CH_IR] = '0;
          end
          MODE_GRAY: begin
            r = int'(drive_lvl[base + CH_RED]);
            bad |= off_target(meas[base + CH_RED]);
            drive_lvl[base + CH_GREEN] = LEVEL_W'((r * 4) / 5);
            drive_lvl[base + CH_BLUE]  = LEVEL_W'((r * 3) / 5);
            drive_lvl[base + CH_IR]    = '0;
          end
          MODE_IR: begin
            bad |= off_target(meas[base + CH_IR]);
            drive_lvl[base + CH_RED]   = '0;
            drive_lvl[base + CH_GREEN] = '0;
            drive_lvl[base + CH_BLUE]  = '0;
          end
          default: ;
        endcase
      end
      if (bad) settle_cnt = '0;
      if (settle_cnt > SETTLE_LIMIT) begin
        res.fin = 1'b1;
      end else if (iter_cnt > ITERATION_LIMIT) begin
        res.fin = 1'b1;
        res.tmo = 1'b1;
      end
      if (settle_cnt != 8'd255) settle_cnt++;
      if (settle_cnt <= SETTLE_LIMIT + 8'd1 && !res.fin || res.tmo) begin
        if (iter_cnt != 8'd255) iter_cnt++;
      end
    end
    res.lvl = drive_lvl;
    return res;
  endfunction

  task automatic note_mismatch(string what, int want_v, int got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
  endtask

  // stop the sender and hold until every predicted result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_AIM:     aim_reg     = data[7:0];
      CFG_TOL:     tol_reg     = data[7:0];
      CFG_GAIN:    gain_reg    = data[GAIN_W-1:0];
      CFG_CEILING: ceiling_reg = data[LEVEL_W-1:0];
      CFG_MODE:    mode_reg    = data[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_scan_item(logic kind, level_vec_t vals);
    if (!no_idle) begin
      while ($urandom_range(99) < 20) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tuser  <= kind;
    s_axis_tdata  <= vals;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_drive.push_back(calibrate_step(kind, vals));
    sent_items++;
    @(negedge clk_i);
  endtask

  function automatic level_vec_t fill_levels(logic [LEVEL_W-1:0] v);
    level_vec_t lv;
    for (int i = 0; i < CH_COUNT; i++) lv[i] = v;
    return lv;
  endfunction

  function automatic level_vec_t random_levels();
    level_vec_t lv;
    for (int i = 0; i < CH_COUNT; i++) lv[i] = LEVEL_W'($urandom);
    return lv;
  endfunction

  // measured maxima scattered around the aim, clipped to the field range
  function automatic level_vec_t near_aim(int spread);
    level_vec_t lv;
    int v;
    for (int i = 0; i < CH_COUNT; i++) begin
      v = int'(aim_reg) + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      lv[i] = LEVEL_W'(v);
    end
    return lv;
  endfunction

  task automatic test_reset_defaults();
    send_scan_item(KIND_MEASURE, fill_levels(12'd237));
    send_scan_item(KIND_MEASURE, fill_levels(12'd0));
    send_scan_item(KIND_MEASURE, fill_levels(12'd255));
  endtask

  task automatic test_field_extremes();
    send_scan_item(KIND_START, fill_levels(12'hFFF));
    send_scan_item(KIND_MEASURE, fill_levels(12'hFFF));
    send_scan_item(KIND_START, fill_levels(12'h000));
    send_scan_item(KIND_MEASURE, fill_levels(12'd256));
    send_scan_item(KIND_START, {4{12'hAAA, 12'h555}});
    send_scan_item(KIND_MEASURE, {4{12'h555, 12'hAAA}});
  endtask

  task automatic test_modes();
    logic [1:0] modes [4] = '{MODE_GRAY, MODE_IR, MODE_UNUSED, MODE_COLOR};
    foreach (modes[k]) begin
      write_reg(CFG_MODE, {10'd0, modes[k]});
      send_scan_item(KIND_START, {12'd900, 12'd1100, 12'd700, 12'd1200,
                                  12'd400, 12'd1300, 12'd250, 12'd1000});
      send_scan_item(KIND_MEASURE, {12'd237, 12'd120, 12'd250, 12'd30,
                                    12'd237, 12'd236, 12'd3000, 12'd200});
    end
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_AIM, 12'd0);
    write_reg(CFG_TOL, 12'd0);
    write_reg(CFG_GAIN, 12'd1023);
    write_reg(CFG_CEILING, 12'd4095);
    send_scan_item(KIND_START, fill_levels(12'd4000));
    send_scan_item(KIND_MEASURE, fill_levels(12'd255));
    write_reg(CFG_AIM, 12'd255);
    write_reg(CFG_TOL, 12'd255);
    send_scan_item(KIND_MEASURE, fill_levels(12'd0));
    write_reg(CFG_GAIN, 12'd0);
    send_scan_item(KIND_MEASURE, fill_levels(12'd17));
    // a ceiling under the floor overrides it
    write_reg(CFG_CEILING, 12'd50);
    write_reg(CFG_GAIN, 12'd512);
    send_scan_item(KIND_MEASURE, fill_levels(12'd200));
    write_reg(CFG_CEILING, 12'd100);
    write_reg(CFG_SPARE, 12'hFFF);
    send_scan_item(KIND_MEASURE, fill_levels(12'd255));
  endtask

  // long converged run, then long unconverged run: both counters saturate
  task automatic test_counter_saturation();
    level_vec_t lv;
    no_idle = 1'b1;
    write_reg(CFG_AIM, 12'd200);
    write_reg(CFG_TOL, 12'd10);
    write_reg(CFG_GAIN, 12'd179);
    write_reg(CFG_CEILING, 12'd1333);
    write_reg(CFG_MODE, {10'd0, MODE_COLOR});
    send_scan_item(KIND_START, random_levels());
    repeat (SATURATE_RUN) begin
      lv = near_aim(10);
      lv[CH_IR] = LEVEL_W'($urandom);
      send_scan_item(KIND_MEASURE, lv);
    end
    repeat (SATURATE_RUN) begin
      lv = near_aim(60);
      lv[SIDE_CH + CH_GREEN] = LEVEL_W'($urandom_range(4095, 211));
      send_scan_item(KIND_MEASURE, lv);
    end
    drain_results();
    no_idle = 1'b0;
  endtask

  task automatic test_random_runs();
    int unsigned goal;
    int unsigned runs;
    int unsigned pick;
    int          spread;
    goal = sent_items + RANDOM_ITEMS;
    while (sent_items < goal) begin
      write_reg(CFG_AIM, CFG_DAT_W'($urandom));
      pick = $urandom_range(99);
      write_reg(CFG_TOL, {4'($urandom), (pick < 75) ? 8'($urandom_range(20)) :
                                        (pick < 85) ? 8'd255 : 8'($urandom)});
      write_reg(CFG_GAIN, CFG_DAT_W'($urandom));
      write_reg(CFG_CEILING, ($urandom_range(99) < 15) ? CFG_DAT_W'($urandom_range(99)) :
                                                         CFG_DAT_W'($urandom_range(4095, 100)));
      write_reg(CFG_MODE, {10'($urandom), ($urandom_range(99) < 10) ? MODE_UNUSED :
                                          2'($urandom_range(2))});
      if ($urandom_range(99) < 10) write_reg(CFG_SPARE, CFG_DAT_W'($urandom));
      runs = $urandom_range(4, 1);
      repeat (runs) begin
        send_scan_item(KIND_START, random_levels());
        repeat ($urandom_range(75, 1)) begin
          pick = $urandom_range(99);
          if (pick < 75) begin
            spread = int'(tol_reg);
            send_scan_item(KIND_MEASURE, near_aim(spread));
          end else if (pick < 90) begin
            spread = int'(tol_reg) + 40;
            send_scan_item(KIND_MEASURE, near_aim(spread));
          end else if (pick < 96) begin
            send_scan_item(KIND_MEASURE, random_levels());
          end else begin
            send_scan_item(KIND_START, random_levels());
          end
        end
        if ($urandom_range(99) < 5) drain_results();
      end
    end
  endtask

  always @(negedge clk_i) m_axis_tready <= no_idle || ($urandom_range(99) >= 20);

  always @(posedge clk_i) begin : check_drive_results
    drive_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_drive.size() == 0) begin
        note_mismatch("unexpected result, drive level 0", -1, int'(m_axis_tdata[LEVEL_W-1:0]));
      end else begin
        want = pending_drive.pop_front();
        for (int i = 0; i < CH_COUNT; i++) begin
          if (m_axis_tdata[i*LEVEL_W +: LEVEL_W] !== want.lvl[i])
            note_mismatch($sformatf("drive level %0d", i), int'(want.lvl[i]),
                          int'(m_axis_tdata[i*LEVEL_W +: LEVEL_W]));
        end
        if (m_axis_tlast !== want.fin)
          note_mismatch("finished", int'(want.fin), int'(m_axis_tlast));
        if (m_axis_tuser !== want.tmo)
          note_mismatch("timed_out", int'(want.tmo), int'(m_axis_tuser));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_MEASURE;
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_AIM;
    cfg_data_i    = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_field_extremes();
    test_modes();
    test_register_extremes();
    test_counter_saturation();
    test_random_runs();

    drain_results();
    if (pending_drive.size() != 0) note_mismatch("missing results", 0, pending_drive.size());
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
